/* src/bsgn_pkg.sv */
`default_nettype none
package bsgn_pkg;

    localparam int MAX_BOXES_DEF   = 256;
    localparam int CLASS_COUNT_DEF = 80;
    localparam int RESULT_LIMIT    = 64;
    localparam logic [15:0] THR_RESET = 16'd29491;

    typedef enum logic [4:0] {
        S_LOAD,
        S_CHECK,
        S_EMPTY,
        S_SRT_RDI,
        S_SRT_LDI,
        S_SRT_SCAN,
        S_SRT_DRAIN,
        S_SRT_WR,
        S_SUP_I,
        S_SUP_RA,
        S_SUP_GA,
        S_SUP_J,
        S_SUP_RB,
        S_SUP_GB,
        S_SUP_WAIT,
        S_EM_I,
        S_EM_RA,
        S_EM_GA
    } state_t;

    typedef struct packed {
        logic load;
        logic clr_set;
        logic i_clr;
        logic i_inc;
        logic j_clr;
        logic j_next;
        logic j_inc;
        logic sc_rd_i;
        logic ldi;
        logic scan;
        logic rank_wr;
        logic rank_rd_i;
        logic rank_rd_j;
        logic geo_rd_rank;
        logic sc_rd_rank;
        logic lda;
        logic ldb;
        logic sup_upd;
        logic e_clr;
        logic emit;
        logic emit_empty;
    } ctrl_t;

    typedef struct packed {
        logic cnt_zero;
        logic i_last;
        logic j_last;
        logic supp_i;
        logic supp_j;
        logic iou_done;
        logic out_free;
        logic emit_last;
    } stat_t;

endpackage
`default_nettype wire

/* src/bsgn_ctrl.sv */
`default_nettype none
module bsgn_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire logic           set_end,
    output logic                in_stall,
    input  wire bsgn_pkg::stat_t st,
    output bsgn_pkg::ctrl_t     cmd
);

    bsgn_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bsgn_pkg::S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bsgn_pkg::S_LOAD:
            begin
                if (in_valid && set_end)
                begin
                    state_next = bsgn_pkg::S_CHECK;
                end
            end
            bsgn_pkg::S_CHECK:
            begin
                state_next = st.cnt_zero ? bsgn_pkg::S_EMPTY : bsgn_pkg::S_SRT_RDI;
            end
            bsgn_pkg::S_EMPTY:
            begin
                if (st.out_free)
                begin
                    state_next = bsgn_pkg::S_LOAD;
                end
            end
            bsgn_pkg::S_SRT_RDI:   state_next = bsgn_pkg::S_SRT_LDI;
            bsgn_pkg::S_SRT_LDI:   state_next = bsgn_pkg::S_SRT_SCAN;
            bsgn_pkg::S_SRT_SCAN:
            begin
                if (st.j_last)
                begin
                    state_next = bsgn_pkg::S_SRT_DRAIN;
                end
            end
            bsgn_pkg::S_SRT_DRAIN: state_next = bsgn_pkg::S_SRT_WR;
            bsgn_pkg::S_SRT_WR:
            begin
                state_next = st.i_last ? bsgn_pkg::S_SUP_I : bsgn_pkg::S_SRT_RDI;
            end
            bsgn_pkg::S_SUP_I:
            begin
                if (st.i_last)
                begin
                    state_next = bsgn_pkg::S_EM_I;
                end
                else if (!st.supp_i)
                begin
                    state_next = bsgn_pkg::S_SUP_RA;
                end
            end
            bsgn_pkg::S_SUP_RA:    state_next = bsgn_pkg::S_SUP_GA;
            bsgn_pkg::S_SUP_GA:    state_next = bsgn_pkg::S_SUP_J;
            bsgn_pkg::S_SUP_J:
            begin
                if (!st.supp_j)
                begin
                    state_next = bsgn_pkg::S_SUP_RB;
                end
                else if (st.j_last)
                begin
                    state_next = bsgn_pkg::S_SUP_I;
                end
            end
            bsgn_pkg::S_SUP_RB:    state_next = bsgn_pkg::S_SUP_GB;
            bsgn_pkg::S_SUP_GB:    state_next = bsgn_pkg::S_SUP_WAIT;
            bsgn_pkg::S_SUP_WAIT:
            begin
                if (st.iou_done)
                begin
                    state_next = st.j_last ? bsgn_pkg::S_SUP_I : bsgn_pkg::S_SUP_J;
                end
            end
            bsgn_pkg::S_EM_I:
            begin
                if (!st.supp_i)
                begin
                    state_next = bsgn_pkg::S_EM_RA;
                end
            end
            bsgn_pkg::S_EM_RA:     state_next = bsgn_pkg::S_EM_GA;
            bsgn_pkg::S_EM_GA:
            begin
                if (st.out_free)
                begin
                    state_next = st.emit_last ? bsgn_pkg::S_LOAD : bsgn_pkg::S_EM_I;
                end
            end
            default:               state_next = bsgn_pkg::S_LOAD;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            bsgn_pkg::S_LOAD:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            bsgn_pkg::S_CHECK:
            begin
                cmd.i_clr = 1'b1;
            end
            bsgn_pkg::S_EMPTY:
            begin
                if (st.out_free)
                begin
                    cmd.emit_empty = 1'b1;
                    cmd.clr_set    = 1'b1;
                end
            end
            bsgn_pkg::S_SRT_RDI:
            begin
                cmd.sc_rd_i = 1'b1;
            end
            bsgn_pkg::S_SRT_LDI:
            begin
                cmd.ldi   = 1'b1;
                cmd.j_clr = 1'b1;
            end
            bsgn_pkg::S_SRT_SCAN:
            begin
                cmd.scan  = 1'b1;
                cmd.j_inc = 1'b1;
            end
            bsgn_pkg::S_SRT_DRAIN:
            begin
            end
            bsgn_pkg::S_SRT_WR:
            begin
                cmd.rank_wr = 1'b1;
                cmd.i_clr   = st.i_last;
                cmd.i_inc   = !st.i_last;
            end
            bsgn_pkg::S_SUP_I:
            begin
                if (st.i_last)
                begin
                    cmd.i_clr = 1'b1;
                    cmd.e_clr = 1'b1;
                end
                else if (st.supp_i)
                begin
                    cmd.i_inc = 1'b1;
                end
                else
                begin
                    cmd.rank_rd_i = 1'b1;
                end
            end
            bsgn_pkg::S_SUP_RA:
            begin
                cmd.geo_rd_rank = 1'b1;
                cmd.j_next      = 1'b1;
            end
            bsgn_pkg::S_SUP_GA:
            begin
                cmd.lda = 1'b1;
            end
            bsgn_pkg::S_SUP_J:
            begin
                if (!st.supp_j)
                begin
                    cmd.rank_rd_j = 1'b1;
                end
                else if (st.j_last)
                begin
                    cmd.i_inc = 1'b1;
                end
                else
                begin
                    cmd.j_inc = 1'b1;
                end
            end
            bsgn_pkg::S_SUP_RB:
            begin
                cmd.geo_rd_rank = 1'b1;
            end
            bsgn_pkg::S_SUP_GB:
            begin
                cmd.ldb = 1'b1;
            end
            bsgn_pkg::S_SUP_WAIT:
            begin
                if (st.iou_done)
                begin
                    cmd.sup_upd = 1'b1;
                    cmd.i_inc   = st.j_last;
                    cmd.j_inc   = !st.j_last;
                end
            end
            bsgn_pkg::S_EM_I:
            begin
                if (st.supp_i)
                begin
                    cmd.i_inc = 1'b1;
                end
                else
                begin
                    cmd.rank_rd_i = 1'b1;
                end
            end
            bsgn_pkg::S_EM_RA:
            begin
                cmd.geo_rd_rank = 1'b1;
                cmd.sc_rd_rank  = 1'b1;
            end
            bsgn_pkg::S_EM_GA:
            begin
                if (st.out_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.i_inc   = 1'b1;
                    cmd.clr_set = st.emit_last;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule
`default_nettype wire

/* src/bsgn_dp.sv */
`default_nettype none
module bsgn_dp #(
    parameter int MAX_BOXES   = bsgn_pkg::MAX_BOXES_DEF,
    parameter int CLASS_COUNT = bsgn_pkg::CLASS_COUNT_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire bsgn_pkg::ctrl_t     cmd,
    output bsgn_pkg::stat_t          st,
    input  wire logic                cfg_write,
    input  wire logic [15:0]         cfg_data,
    input  wire logic                box_valid,
    input  wire logic [15:0]         center_x,
    input  wire logic [15:0]         center_y,
    input  wire logic [15:0]         box_width,
    input  wire logic [15:0]         box_height,
    input  wire logic [15:0]         score,
    input  wire logic [6:0]          class_id,
    input  wire logic                out_stall,
    output logic                     out_valid,
    output logic [6:0]               class_label,
    output logic [15:0]              kept_score,
    output logic signed [17:0]       box_left,
    output logic signed [17:0]       box_top,
    output logic signed [17:0]       box_right,
    output logic signed [17:0]       box_bottom,
    output logic                     no_detection,
    output logic                     overflowed,
    output logic                     last_result
);

    localparam int IDX_W = $clog2(MAX_BOXES);
    localparam int CNT_W = IDX_W + 1;
    localparam int E_W   = $clog2(bsgn_pkg::RESULT_LIMIT + 1);
    localparam int TW    = (CNT_W > E_W) ? CNT_W : E_W;

    // stores
    logic [63:0]      geo_mem [MAX_BOXES];
    logic [22:0]      sc_mem  [MAX_BOXES];
    logic [IDX_W-1:0] rank_mem[MAX_BOXES];
    logic [63:0]      geo_q;
    logic [22:0]      sc_q;
    logic [IDX_W-1:0] rank_q;

    logic [15:0]          thr_reg;
    logic [CNT_W-1:0]     count_reg;
    logic                 ovf_reg;
    logic [MAX_BOXES-1:0] supp_reg;
    logic [CNT_W-1:0]     supp_cnt_reg;
    logic [IDX_W-1:0]     i_reg, j_reg, jd_reg, rcnt_reg;
    logic                 pv_reg;
    logic [15:0]          si_reg;
    logic [E_W-1:0]       e_reg;

    logic [6:0]  cls_in;
    logic [63:0] a_reg, b_reg;

    always_comb
    begin
        cls_in = class_id;
        if ({25'd0, class_id} >= 32'(CLASS_COUNT))
        begin
            cls_in = 7'(CLASS_COUNT - 1);
        end
    end

    logic             full;
    logic [IDX_W-1:0] sc_addr;
    assign full = (count_reg >= CNT_W'(MAX_BOXES));

    always_comb
    begin
        sc_addr = rank_q;
        if (cmd.sc_rd_i)
        begin
            sc_addr = i_reg;
        end
        else if (cmd.scan)
        begin
            sc_addr = j_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && box_valid && !full)
        begin
            geo_mem[count_reg[IDX_W-1:0]] <= {box_height, box_width, center_y, center_x};
            sc_mem[count_reg[IDX_W-1:0]]  <= {cls_in, score};
        end
        if (cmd.rank_wr)
        begin
            rank_mem[rcnt_reg] <= i_reg;
        end
        if (cmd.sc_rd_i || cmd.scan || cmd.sc_rd_rank)
        begin
            sc_q <= sc_mem[sc_addr];
        end
        if (cmd.geo_rd_rank)
        begin
            geo_q <= geo_mem[rank_q];
        end
        if (cmd.rank_rd_i || cmd.rank_rd_j)
        begin
            rank_q <= rank_mem[cmd.rank_rd_i ? i_reg : j_reg];
        end
    end

    // set bookkeeping and counters
    logic sort_hit;
    assign sort_hit = (sc_q[15:0] > si_reg) || ((sc_q[15:0] == si_reg) && (jd_reg < i_reg));

    logic iou_hit, iou_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg      <= bsgn_pkg::THR_RESET;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            supp_reg     <= '0;
            supp_cnt_reg <= '0;
            pv_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                thr_reg <= cfg_data;
            end
            pv_reg <= cmd.scan;
            if (cmd.clr_set)
            begin
                count_reg    <= '0;
                ovf_reg      <= 1'b0;
                supp_reg     <= '0;
                supp_cnt_reg <= '0;
            end
            else
            begin
                if (cmd.load && box_valid)
                begin
                    if (full)
                    begin
                        ovf_reg <= 1'b1;
                    end
                    else
                    begin
                        count_reg <= count_reg + 1'b1;
                    end
                end
                if (cmd.sup_upd && iou_hit && !supp_reg[j_reg])
                begin
                    supp_reg[j_reg] <= 1'b1;
                    supp_cnt_reg    <= supp_cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.i_clr)
        begin
            i_reg <= '0;
        end
        else if (cmd.i_inc)
        begin
            i_reg <= i_reg + 1'b1;
        end
        if (cmd.j_clr)
        begin
            j_reg <= '0;
        end
        else if (cmd.j_next)
        begin
            j_reg <= i_reg + 1'b1;
        end
        else if (cmd.j_inc)
        begin
            j_reg <= j_reg + 1'b1;
        end
        jd_reg <= j_reg;
        if (cmd.ldi)
        begin
            si_reg   <= sc_q[15:0];
            rcnt_reg <= '0;
        end
        else if (pv_reg && sort_hit)
        begin
            rcnt_reg <= rcnt_reg + 1'b1;
        end
        if (cmd.e_clr)
        begin
            e_reg <= '0;
        end
        else if (cmd.emit)
        begin
            e_reg <= e_reg + 1'b1;
        end
        if (cmd.lda)
        begin
            a_reg <= geo_q;
        end
        if (cmd.ldb)
        begin
            b_reg <= geo_q;
        end
    end

    // overlap test: inter*2^16 >= thr*union, doubled-unit edges
    logic v0_reg, v1_reg, v2_reg, v3_reg, v4_reg, done_reg;
    logic signed [19:0] ow_reg, oh_reg;
    logic [31:0] area_a_reg, area_b_reg;
    logic [33:0] inter_reg, inter3_reg, inter4_reg;
    logic [32:0] asum_reg;
    logic [34:0] union_reg;
    logic [50:0] prod_reg;
    logic        uzero_reg, hit_reg;

    function automatic logic signed [19:0] overlap2(input logic [15:0] c1, input logic [15:0] s1,
                                                    input logic [15:0] c2, input logic [15:0] s2);
        logic signed [19:0] lo1, lo2, hi1, hi2, lo, hi;
        lo1 = $signed({3'd0, c1, 1'b0}) - $signed({4'd0, s1});
        hi1 = $signed({3'd0, c1, 1'b0}) + $signed({4'd0, s1});
        lo2 = $signed({3'd0, c2, 1'b0}) - $signed({4'd0, s2});
        hi2 = $signed({3'd0, c2, 1'b0}) + $signed({4'd0, s2});
        lo  = (lo1 > lo2) ? lo1 : lo2;
        hi  = (hi1 < hi2) ? hi1 : hi2;
        return hi - lo;
    endfunction

    // done follows b_reg through the five pipeline stages up to hit_reg
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg   <= 1'b0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v0_reg   <= cmd.ldb;
            v1_reg   <= v0_reg;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            done_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ow_reg     <= overlap2(a_reg[15:0], a_reg[47:32], b_reg[15:0], b_reg[47:32]);
        oh_reg     <= overlap2(a_reg[31:16], a_reg[63:48], b_reg[31:16], b_reg[63:48]);
        area_a_reg <= a_reg[47:32] * a_reg[63:48];
        area_b_reg <= b_reg[47:32] * b_reg[63:48];
        if ((ow_reg > 20'sd0) && (oh_reg > 20'sd0))
        begin
            inter_reg <= ow_reg[16:0] * oh_reg[16:0];
        end
        else
        begin
            inter_reg <= '0;
        end
        asum_reg   <= {1'b0, area_a_reg} + {1'b0, area_b_reg};
        union_reg  <= {asum_reg, 2'b00} - {1'b0, inter_reg};
        inter3_reg <= inter_reg;
        prod_reg   <= thr_reg * union_reg;
        uzero_reg  <= (union_reg == '0);
        inter4_reg <= inter3_reg;
        hit_reg    <= !uzero_reg && ({1'b0, inter4_reg, 16'd0} >= prod_reg);
    end

    assign iou_hit  = hit_reg;
    assign iou_done = done_reg;

    // emission bookkeeping
    logic [TW-1:0] kept, total;
    assign kept  = TW'(count_reg) - TW'(supp_cnt_reg);
    assign total = (kept > TW'(bsgn_pkg::RESULT_LIMIT)) ? TW'(bsgn_pkg::RESULT_LIMIT) : kept;

    logic out_free;
    assign out_free = !out_valid || !out_stall;

    always_comb
    begin
        st.cnt_zero  = (count_reg == '0);
        st.i_last    = ({1'b0, i_reg} == count_reg - 1'b1);
        st.j_last    = ({1'b0, j_reg} == count_reg - 1'b1);
        st.supp_i    = supp_reg[i_reg];
        st.supp_j    = supp_reg[j_reg];
        st.iou_done  = iou_done;
        st.out_free  = out_free;
        st.emit_last = (TW'(e_reg) + 1'b1 == total);
    end

    // result register
    logic signed [18:0] l19, t19, r19, b19;
    assign l19 = $signed({2'd0, geo_q[15:0], 1'b0}) - $signed({3'd0, geo_q[47:32]});
    assign r19 = $signed({2'd0, geo_q[15:0], 1'b0}) + $signed({3'd0, geo_q[47:32]});
    assign t19 = $signed({2'd0, geo_q[31:16], 1'b0}) - $signed({3'd0, geo_q[63:48]});
    assign b19 = $signed({2'd0, geo_q[31:16], 1'b0}) + $signed({3'd0, geo_q[63:48]});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (cmd.emit || cmd.emit_empty)
        begin
            out_valid <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            class_label  <= sc_q[22:16] + 7'd1;
            kept_score   <= sc_q[15:0];
            box_left     <= l19[18:1];
            box_top      <= t19[18:1];
            box_right    <= r19[18:1];
            box_bottom   <= b19[18:1];
            no_detection <= 1'b0;
            overflowed   <= ovf_reg;
            last_result  <= st.emit_last;
        end
        else if (cmd.emit_empty)
        begin
            class_label  <= '0;
            kept_score   <= '0;
            box_left     <= '0;
            box_top      <= '0;
            box_right    <= '0;
            box_bottom   <= '0;
            no_detection <= 1'b1;
            overflowed   <= ovf_reg;
            last_result  <= 1'b1;
        end
    end

endmodule
`default_nettype wire

/* src/box_sort_and_greedy_nms.sv */
`default_nettype none
// Greedy NMS over one buffered set of up to MAX_BOXES boxes. Boxes are taken one per cycle
// while loading; the transaction with set_end closes the set and input stalls until the last
// result of the set has been handed to the output register. Ranking makes one score-memory
// read per comparison, suppression does a geometry read plus a 5-stage overlap pipeline for
// each pair still open, and each result can be held back by output stalls. Threshold writes
// should happen between sets.
module box_sort_and_greedy_nms #(
    parameter int MAX_BOXES   = bsgn_pkg::MAX_BOXES_DEF,
    parameter int CLASS_COUNT = bsgn_pkg::CLASS_COUNT_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_write,
    input  wire logic [15:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               box_valid,
    input  wire logic [15:0]        center_x,
    input  wire logic [15:0]        center_y,
    input  wire logic [15:0]        box_width,
    input  wire logic [15:0]        box_height,
    input  wire logic [15:0]        score,
    input  wire logic [6:0]         class_id,
    input  wire logic               set_end,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [6:0]              class_label,
    output logic [15:0]             kept_score,
    output logic signed [17:0]      box_left,
    output logic signed [17:0]      box_top,
    output logic signed [17:0]      box_right,
    output logic signed [17:0]      box_bottom,
    output logic                    no_detection,
    output logic                    overflowed,
    output logic                    last_result
);

    bsgn_pkg::ctrl_t cmd;
    bsgn_pkg::stat_t st;

    bsgn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .set_end  (set_end),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    bsgn_dp #(
        .MAX_BOXES   (MAX_BOXES),
        .CLASS_COUNT (CLASS_COUNT)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .st           (st),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .box_valid    (box_valid),
        .center_x     (center_x),
        .center_y     (center_y),
        .box_width    (box_width),
        .box_height   (box_height),
        .score        (score),
        .class_id     (class_id),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .class_label  (class_label),
        .kept_score   (kept_score),
        .box_left     (box_left),
        .box_top      (box_top),
        .box_right    (box_right),
        .box_bottom   (box_bottom),
        .no_detection (no_detection),
        .overflowed   (overflowed),
        .last_result  (last_result)
    );

endmodule
`default_nettype wire

/* src/bsgn_chk.sv */
`default_nettype none
module bsgn_chk (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [6:0]  class_label,
    input wire logic [15:0] kept_score,
    input wire logic        no_detection,
    input wire logic        last_result
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && no_detection |-> class_label == 7'd0 && kept_score == 16'd0 && last_result)
        else $error("no-detection result malformed");

    a_label: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !no_detection |-> class_label != 7'd0)
        else $error("kept box with zero label");

    a_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=>
            $stable({class_label, kept_score, no_detection, last_result}))
        else $error("result changed while stalled");

endmodule

bind box_sort_and_greedy_nms bsgn_chk u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .class_label  (class_label),
    .kept_score   (kept_score),
    .no_detection (no_detection),
    .last_result  (last_result)
);
`default_nettype wire

/* tb/sv/box_sort_and_greedy_nms_test.sv */
module box_sort_and_greedy_nms_test;

    typedef struct packed {
        logic        present;
        logic [15:0] cx;
        logic [15:0] cy;
        logic [15:0] w;
        logic [15:0] h;
        logic [15:0] conf;
        logic [6:0]  cls;
        logic        last;
    } cand_t;

    typedef struct packed {
        logic [6:0]         label;
        logic [15:0]        conf;
        logic signed [17:0] left;
        logic signed [17:0] top;
        logic signed [17:0] right;
        logic signed [17:0] bottom;
        logic               none;
        logic               ovf;
        logic               last;
    } det_t;

    class nms_scoreboard;
        cand_t  held[$];
        logic   spilled;
        logic [15:0] thr;
        det_t   pending[$];
        int     errors;

        function new();
            spilled = 0;
            thr = bsgn_pkg::THR_RESET;
            errors = 0;
        endfunction

        function automatic bit overlaps(cand_t a, cand_t b);
            longint ax, ay, aw, ah, bx, by, bw, bh;
            longint ow, oh, lo, hi, inter, uni;
            ax = a.cx; ay = a.cy; aw = a.w; ah = a.h;
            bx = b.cx; by = b.cy; bw = b.w; bh = b.h;
            lo = (2*ax - aw) > (2*bx - bw) ? (2*ax - aw) : (2*bx - bw);
            hi = (2*ax + aw) < (2*bx + bw) ? (2*ax + aw) : (2*bx + bw);
            ow = hi - lo;
            lo = (2*ay - ah) > (2*by - bh) ? (2*ay - ah) : (2*by - bh);
            hi = (2*ay + ah) < (2*by + bh) ? (2*ay + ah) : (2*by + bh);
            oh = hi - lo;
            inter = (ow > 0 && oh > 0) ? ow * oh : 0;
            uni = 4 * (aw * ah + bw * bh) - inter;
            if (uni == 0) return 0;
            return (inter <<< 16) >= longint'(thr) * uni;
        endfunction

        function automatic logic [17:0] half_floor(longint d);
            return 18'(d >>> 1);
        endfunction

        function void note_input(cand_t c);
            cand_t ranked[$];
            bit    gone[$];
            det_t  d;
            int    pos, made;
            if (c.present) begin
                if (held.size() < bsgn_pkg::MAX_BOXES_DEF) begin
                    if (c.cls >= bsgn_pkg::CLASS_COUNT_DEF)
                        c.cls = 7'(bsgn_pkg::CLASS_COUNT_DEF - 1);
                    held.insert(held.size(), c);
                end else
                    spilled = 1;
            end
            if (!c.last) return;
            if (held.size() == 0) begin
                d = '0;
                d.none = 1;
                d.ovf = spilled;
                d.last = 1;
                pending.insert(pending.size(), d);
            end else begin
                foreach (held[k]) begin
                    pos = ranked.size();
                    while (pos > 0 && ranked[pos-1].conf < held[k].conf) pos--;
                    ranked.insert(pos, held[k]);
                    gone.insert(gone.size(), 0);
                end
                foreach (ranked[i])
                    if (!gone[i])
                        for (int j = i + 1; j < ranked.size(); j++)
                            if (!gone[j] && overlaps(ranked[i], ranked[j])) gone[j] = 1;
                made = 0;
                foreach (ranked[i])
                    if (!gone[i] && made < bsgn_pkg::RESULT_LIMIT) begin
                        d = '0;
                        d.label = ranked[i].cls + 7'd1;
                        d.conf = ranked[i].conf;
                        d.left = half_floor(2*longint'(ranked[i].cx) - ranked[i].w);
                        d.top = half_floor(2*longint'(ranked[i].cy) - ranked[i].h);
                        d.right = half_floor(2*longint'(ranked[i].cx) + ranked[i].w);
                        d.bottom = half_floor(2*longint'(ranked[i].cy) + ranked[i].h);
                        d.ovf = spilled;
                        pending.insert(pending.size(), d);
                        made++;
                    end
                pending[pending.size()-1].last = 1;
            end
            held.delete();
            spilled = 0;
        endfunction

        function void check_result(det_t got);
            det_t e;
            if (pending.size() == 0) begin
                $error("unexpected result label=%0d", got.label);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.label !== e.label) begin
                $error("class_label exp %0d got %0d", e.label, got.label); errors++; end
            if (got.conf !== e.conf) begin
                $error("kept_score exp %0d got %0d", e.conf, got.conf); errors++; end
            if (got.left !== e.left) begin
                $error("box_left exp %0d got %0d", e.left, got.left); errors++; end
            if (got.top !== e.top) begin
                $error("box_top exp %0d got %0d", e.top, got.top); errors++; end
            if (got.right !== e.right) begin
                $error("box_right exp %0d got %0d", e.right, got.right); errors++; end
            if (got.bottom !== e.bottom) begin
                $error("box_bottom exp %0d got %0d", e.bottom, got.bottom); errors++; end
            if (got.none !== e.none) begin
                $error("no_detection exp %0d got %0d", e.none, got.none); errors++; end
            if (got.ovf !== e.ovf) begin
                $error("overflowed exp %0d got %0d", e.ovf, got.ovf); errors++; end
            if (got.last !== e.last) begin
                $error("last_result exp %0d got %0d", e.last, got.last); errors++; end
        endfunction
    endclass

    logic clk, rst_n;
    logic cfg_write;
    logic [15:0] cfg_data;
    logic in_valid, in_stall, out_valid, out_stall;
    logic box_valid, set_end;
    logic [15:0] center_x, center_y, box_width, box_height, score;
    logic [6:0] class_id, class_label;
    logic [15:0] kept_score;
    logic signed [17:0] box_left, box_top, box_right, box_bottom;
    logic no_detection, overflowed, last_result;

    nms_scoreboard board;
    int  long_hold;
    longint cycles;

    box_sort_and_greedy_nms u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .box_valid(box_valid), .center_x(center_x), .center_y(center_y),
        .box_width(box_width), .box_height(box_height), .score(score),
        .class_id(class_id), .set_end(set_end),
        .out_valid(out_valid), .out_stall(out_stall),
        .class_label(class_label), .kept_score(kept_score),
        .box_left(box_left), .box_top(box_top), .box_right(box_right),
        .box_bottom(box_bottom), .no_detection(no_detection),
        .overflowed(overflowed), .last_result(last_result)
    );

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 64'd40_000_000)
            begin
                $display("box_sort_and_greedy_nms_test: done, errors");
                $finish;
            end
        end
    end

    // receiver: own stall pattern, plus one long hold-off on request
    initial
    begin
        int mode;
        out_stall = 0;
        forever
        begin
            @(negedge clk);
            if (long_hold > 0)
            begin
                out_stall <= 1;
                long_hold--;
            end
            else
            begin
                mode = (cycles / 500) % 3;
                if (mode == 0) out_stall <= 0;
                else if (mode == 1) out_stall <= ($urandom_range(0, 3) == 0);
                else out_stall <= ($urandom_range(0, 1) == 0);
            end
        end
    end

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            board.check_result('{class_label, kept_score, box_left, box_top, box_right,
                                 box_bottom, no_detection, overflowed, last_result});

    int gap_left;

    // returns at the falling edge after the accepting edge; in_valid is left for the
    // next caller to set
    task automatic send(cand_t c);
        if (gap_left == 0 && $urandom_range(0, 5) == 0)
            gap_left = $urandom_range(1, 12);
        while (gap_left > 0)
        begin
            in_valid <= 0;
            gap_left--;
            @(negedge clk);
        end
        in_valid <= 1;
        {box_valid, center_x, center_y, box_width, box_height, score, class_id, set_end}
            <= c;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        board.note_input(c);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (board.pending.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_thr(logic [15:0] v);
        cfg_write <= 1;
        cfg_data <= v;
        @(negedge clk);
        cfg_write <= 0;
        board.thr = v;
    endtask

    function automatic cand_t rand_box(bit last);
        cand_t c;
        c.present = 1;
        c.cx = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(1000, 9000));
        c.cy = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(1000, 9000));
        c.w = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 4000));
        c.h = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 4000));
        c.conf = $urandom_range(0, 2) == 0 ? 16'($urandom_range(0, 7)) * 16'd9000
                                           : 16'($urandom);
        c.cls = $urandom_range(0, 9) == 0 ? 7'($urandom) : 7'($urandom_range(0, 79));
        c.last = last;
        return c;
    endfunction

    initial
    begin
        cand_t c;
        int n;
        board = new();
        long_hold = 0;
        gap_left = 0;
        rst_n = 0;
        cfg_write = 0;
        cfg_data = 0;
        in_valid = 0;
        {box_valid, center_x, center_y, box_width, box_height, score, class_id, set_end} = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: empty set, ignored filler, extremes, ties, zero areas, clamp
        send('{0, 16'hFFFF, 0, 0, 0, 0, 0, 1});
        send('{0, 16'h1234, 16'h5678, 1, 1, 1, 1, 0});
        send('{1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 7'h7F, 0});
        send('{1, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 7'd79, 0});
        send('{1, 0, 0, 0, 0, 0, 7'd0, 0});
        send('{1, 100, 100, 0, 0, 5, 7'd3, 0});
        send('{1, 100, 100, 0, 0, 5, 7'd4, 0});
        send('{1, 4096, 4096, 1000, 1000, 500, 7'd80, 0});
        send('{1, 4100, 4096, 1000, 1000, 500, 7'd5, 0});
        send('{0, 0, 0, 0, 0, 0, 0, 1});
        send('{1, 2000, 2000, 1, 3, 7, 7'd1, 1});
        drain();
        write_thr(16'd0);
        send('{1, 4096, 4096, 1000, 1000, 900, 7'd2, 0});
        send('{1, 9000, 9000, 10, 10, 800, 7'd2, 0});
        send('{1, 9000, 9000, 0, 0, 700, 7'd2, 1});
        drain();
        write_thr(16'hFFFF);
        send('{1, 4096, 4096, 1000, 1000, 900, 7'd2, 0});
        send('{1, 4096, 4096, 1000, 1000, 900, 7'd6, 1});
        drain();

        // overflow set: capacity plus one; the high threshold leaves more survivors
        // than the result limit
        for (int k = 0; k < bsgn_pkg::MAX_BOXES_DEF + 1; k++)
        begin
            c = rand_box(k == bsgn_pkg::MAX_BOXES_DEF);
            send(c);
        end
        drain();

        // long receiver hold while the next sets are offered
        write_thr(bsgn_pkg::THR_RESET);
        long_hold = 2000;
        for (int k = 0; k < 4; k++) send(rand_box(k == 3));
        for (int k = 0; k < 4; k++) send(rand_box(k == 3));
        drain();

        // random sets, mostly small
        for (int s = 0; s < 6; s++)
        begin
            if (s == 3)
            begin
                drain();
                write_thr(16'($urandom));
            end
            n = $urandom_range(0, 4);
            for (int k = 0; k < n; k++)
            begin
                c = rand_box(0);
                if ($urandom_range(0, 7) == 0) c.present = 0;
                send(c);
            end
            c = rand_box(1);
            c.present = $urandom_range(0, 3) != 0;
            send(c);
        end
        drain();

        if (board.errors == 0)
            $display("box_sort_and_greedy_nms_test: done, clean");
        else
            $display("box_sort_and_greedy_nms_test: done, errors");
        $finish;
    end
endmodule
